### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define SCM_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

### src/scmon_pkg.sv
// ----------------------------------------------------------------------------
// scmon_pkg
// shared types and constants of the step change monitor
// ----------------------------------------------------------------------------
`default_nettype none

package scmon_pkg;

    localparam int NUM_DEVICES_DEF = 32;

    localparam int DEV_W  = 5;
    localparam int VOLT_W = 16;
    localparam int CNT_W  = 16;
    localparam int RDC_W  = 16;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] CHANGE_LIMIT_RST  = 16'd30;
    localparam logic [CFG_W-1:0] REPORT_PERIOD_RST = 16'd30;
    localparam logic [CNT_W-1:0] CNT_MAX           = '1;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_CHANGE_LIMIT  = 1'b0,
        CFG_REPORT_PERIOD = 1'b1
    } t_cfg_idx;

    // one store word per device
    typedef struct packed {
        logic [VOLT_W-1:0] last;
        logic [CNT_W-1:0]  cnt;
    } t_mem_word;

    // registered read of the store
    typedef struct packed {
        logic      vld;
        t_mem_word word;
    } t_entry;

    // results of one evaluation
    typedef struct packed {
        logic             warn;
        logic             wr_en;
        t_mem_word        wr_word;
        logic [DEV_W-1:0] best;
        logic [CNT_W-1:0] best_cnt;
        logic [RDC_W-1:0] read_cnt;
        logic             report;
    } t_calc_res;

endpackage

`default_nettype wire

### src/scmon_store.sv
// ----------------------------------------------------------------------------
// scmon_store
// per device memory of last voltage and warning count with valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module scmon_store #(
    parameter int NUM_DEVICES = scmon_pkg::NUM_DEVICES_DEF,
    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr,
    output scmon_pkg::t_entry         o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire scmon_pkg::t_mem_word i_wr_data
);

    scmon_pkg::t_mem_word r_mem [NUM_DEVICES];
    logic [NUM_DEVICES-1:0] r_vld;

    scmon_pkg::t_mem_word r_rd_word;
    scmon_pkg::t_mem_word r_byp_word;
    logic                 r_byp;
    logic                 r_rd_vld;
    logic                 n_hit;

    // write in the same cycle as the read wins
    assign n_hit = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word  <= r_mem[i_rd_addr];
            r_byp_word <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_byp    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_byp    <= n_hit;
                r_rd_vld <= r_vld[i_rd_addr] | n_hit;
            end
        end
    end

    // entry never written reads as zero
    always_comb begin
        o_rd_data.vld = r_rd_vld;
        if (!r_rd_vld) begin
            o_rd_data.word = '0;
        end else if (r_byp) begin
            o_rd_data.word = r_byp_word;
        end else begin
            o_rd_data.word = r_rd_word;
        end
    end

endmodule

`default_nettype wire

### src/scmon_calc.sv
// ----------------------------------------------------------------------------
// scmon_calc
// step check, count update, running busiest device and report period
// ----------------------------------------------------------------------------
`default_nettype none

module scmon_calc #(
    parameter int NUM_DEVICES = scmon_pkg::NUM_DEVICES_DEF
) (
    input  wire logic [scmon_pkg::DEV_W-1:0]  i_dev,
    input  wire logic [scmon_pkg::VOLT_W-1:0] i_volt,
    input  wire scmon_pkg::t_entry            i_entry,
    input  wire logic [scmon_pkg::CFG_W-1:0]  i_change_limit,
    input  wire logic [scmon_pkg::CFG_W-1:0]  i_report_period,
    input  wire logic [scmon_pkg::DEV_W-1:0]  i_best,
    input  wire logic [scmon_pkg::CNT_W-1:0]  i_best_cnt,
    input  wire logic [scmon_pkg::RDC_W-1:0]  i_read_cnt,
    output scmon_pkg::t_calc_res              o_res
);

    logic                            in_range;
    logic [scmon_pkg::VOLT_W-1:0]    prev;
    logic [scmon_pkg::VOLT_W:0]      diff;
    logic [scmon_pkg::VOLT_W:0]      mag;
    logic [scmon_pkg::CNT_W-1:0]     cnt;
    logic [scmon_pkg::CNT_W-1:0]     cnt_nxt;
    logic                            cnt_inc;
    logic                            take_best;
    logic [scmon_pkg::RDC_W-1:0]     rdc_inc;
    logic [scmon_pkg::CFG_W-1:0]     period;

    assign in_range = 32'(i_dev) < 32'(NUM_DEVICES);
    assign prev     = i_entry.word.last;
    assign cnt      = i_entry.word.cnt;

    // signed difference, one bit wider
    assign diff = {i_volt[scmon_pkg::VOLT_W-1], i_volt} - {prev[scmon_pkg::VOLT_W-1], prev};
    assign mag  = diff[scmon_pkg::VOLT_W] ? (~diff + 1'b1) : diff;

    assign o_res.warn = in_range && (prev != '0) && (mag > {1'b0, i_change_limit});

    // count saturates, best device follows only a real increment
    assign cnt_inc   = o_res.warn && (cnt != scmon_pkg::CNT_MAX);
    assign cnt_nxt   = cnt + 1'b1;
    assign take_best = cnt_inc && ((cnt_nxt > i_best_cnt) ||
                                   ((cnt_nxt == i_best_cnt) && (i_dev < i_best)));

    assign o_res.wr_en        = in_range;
    assign o_res.wr_word.last = i_volt;
    assign o_res.wr_word.cnt  = cnt_inc ? cnt_nxt : cnt;
    assign o_res.best         = take_best ? i_dev : i_best;
    assign o_res.best_cnt     = take_best ? cnt_nxt : i_best_cnt;

    // zero period behaves as one
    assign period         = (i_report_period == '0) ? 16'd1 : i_report_period;
    assign rdc_inc        = i_read_cnt + 1'b1;
    assign o_res.report   = rdc_inc >= period;
    assign o_res.read_cnt = o_res.report ? '0 : rdc_inc;

endmodule

`default_nettype wire

### src/per_channel_step_change_monitor_unit.sv
// ----------------------------------------------------------------------------
// per_channel_step_change_monitor_unit
// per device step change monitor with periodic busiest device report
// ----------------------------------------------------------------------------
// path: reading and store read registered at accept, then the result register
// throughput: one reading per cycle unless the output stalls, set by the single store
//   port pair (one read at accept, one write as the reading leaves the input stage)
// reset: synchronous active low; clears valid bits of the store, counters,
//   running best device and pipeline valids; registers return to 30
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module per_channel_step_change_monitor_unit #(
    parameter int NUM_DEVICES = scmon_pkg::NUM_DEVICES_DEF,
    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [0:0]                  i_cfg_idx,
    input  wire logic [scmon_pkg::CFG_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [23:0]                 i_s_tdata,   // device_id[4:0], voltage[20:5]
    // result stream
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [7:0]                       o_m_tdata,   // warning[0], busiest_device[5:1]
    output logic                             o_m_tuser    // report_valid
);

    // configuration registers
    logic [scmon_pkg::CFG_W-1:0] r_change_limit;
    logic [scmon_pkg::CFG_W-1:0] r_report_period;

    // input stage
    logic                          r_s1_vld;
    logic [scmon_pkg::DEV_W-1:0]   r_s1_dev;
    logic [scmon_pkg::VOLT_W-1:0]  r_s1_volt;

    // running state
    logic [scmon_pkg::DEV_W-1:0]   r_best;
    logic [scmon_pkg::CNT_W-1:0]   r_best_cnt;   // warning count of r_best
    logic [scmon_pkg::RDC_W-1:0]   r_read_cnt;

    // result register
    logic                          r_out_vld;
    logic                          r_out_warn;
    logic                          r_out_rep;
    logic [scmon_pkg::DEV_W-1:0]   r_out_best;

    logic                          s_accept;
    logic                          s1_adv;
    logic                          n_s1_vld;
    logic                          n_out_vld;
    logic [scmon_pkg::DEV_W-1:0]   in_dev;
    logic [scmon_pkg::VOLT_W-1:0]  in_volt;
    scmon_pkg::t_entry             rd_entry;
    scmon_pkg::t_calc_res          res;
    logic                          wr_en;

    assign in_dev  = i_s_tdata[4:0];
    assign in_volt = i_s_tdata[20:5];

    // input stage moves on when the result register is free or drained
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || !r_out_vld || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign wr_en      = s1_adv && res.wr_en;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change_limit  <= scmon_pkg::CHANGE_LIMIT_RST;
            r_report_period <= scmon_pkg::REPORT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (scmon_pkg::t_cfg_idx'(i_cfg_idx))
                scmon_pkg::CFG_CHANGE_LIMIT:  r_change_limit  <= i_cfg_data;
                scmon_pkg::CFG_REPORT_PERIOD: r_report_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per device store, read at accept, written as the reading leaves
    // ------------------------------------------------------------------
    scmon_store #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (AW'(in_dev)),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_s1_dev)),
        .i_wr_data (res.wr_word)
    );

    // ------------------------------------------------------------------
    // evaluation between input stage and result register
    // ------------------------------------------------------------------
    scmon_calc #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_calc (
        .i_dev           (r_s1_dev),
        .i_volt          (r_s1_volt),
        .i_entry         (rd_entry),
        .i_change_limit  (r_change_limit),
        .i_report_period (r_report_period),
        .i_best          (r_best),
        .i_best_cnt      (r_best_cnt),
        .i_read_cnt      (r_read_cnt),
        .o_res           (res)
    );

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (s_accept) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (s1_adv) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_best     <= '0;
            r_best_cnt <= '0;
            r_read_cnt <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (s1_adv) begin
                r_best     <= res.best;
                r_best_cnt <= res.best_cnt;
                r_read_cnt <= res.read_cnt;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_dev  <= in_dev;
            r_s1_volt <= in_volt;
        end
        if (s1_adv) begin
            r_out_warn <= res.warn;
            r_out_rep  <= res.report;
            r_out_best <= res.report ? res.best : '0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_best, r_out_warn};
    assign o_m_tuser  = r_out_rep;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no written count ever exceeds the running best count
    `SCM_ASSERT(a_best_is_max, i_clk, i_rst_n, wr_en |=> ($past(res.wr_word.cnt) <= r_best_cnt))
    // a reading leaving the input stage always lands in the result register
    `SCM_ASSERT(a_adv_to_out, i_clk, i_rst_n, s1_adv |=> o_m_tvalid)
    // busiest device is zero outside a report
    `SCM_ASSERT_NEVER(a_best_no_rep, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser && (o_m_tdata[5:1] != '0))

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the per device step change monitor: drives readings
// with random gaps and back pressure, predicts warning, report and busiest
// device for each reading, and compares every result transaction in order
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import scmon_pkg::*;

    // ------------------------------------------------------------------------
    // expected outcome of one reading
    // ------------------------------------------------------------------------
    typedef struct {
        logic             warning;
        logic             report_valid;
        logic [DEV_W-1:0] busiest_device;
    } t_verdict;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of the per device stores and registers,
    // turns each accepted reading into an expected verdict and checks the
    // result transactions against them in order
    // ------------------------------------------------------------------------
    class verdict_board;
        logic [CFG_W-1:0]         change_limit;
        logic [CFG_W-1:0]         report_period;
        logic signed [VOLT_W-1:0] last_volt [NUM_DEVICES_DEF];
        logic [CNT_W-1:0]         warn_cnt [NUM_DEVICES_DEF];
        logic [RDC_W-1:0]         reading_cnt;
        logic [DEV_W-1:0]         busiest;
        t_verdict                 expected_verdicts [$];
        int                       failures;

        function new();
            change_limit  = CHANGE_LIMIT_RST;
            report_period = REPORT_PERIOD_RST;
            for (int d = 0; d < NUM_DEVICES_DEF; d++) begin
                last_volt[d] = '0;
                warn_cnt[d]  = '0;
            end
            reading_cnt = '0;
            busiest     = '0;
            failures    = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] val);
            if (idx == CFG_CHANGE_LIMIT) begin
                change_limit = val;
            end else if (idx == CFG_REPORT_PERIOD) begin
                report_period = val;
            end
        endfunction

        function void note_reading(logic [DEV_W-1:0] dev, logic signed [VOLT_W-1:0] volt);
            int               prev;
            int               diff;
            int               mag;
            logic [DEV_W-1:0] lead;
            logic [RDC_W-1:0] period;
            t_verdict         v;
            v.warning        = 1'b0;
            v.report_valid   = 1'b0;
            v.busiest_device = '0;
            if (dev < NUM_DEVICES_DEF) begin
                prev = int'(last_volt[dev]);
                diff = int'(volt) - prev;
                mag  = (diff < 0) ? -diff : diff;
                // zero stored voltage means no earlier reading
                if (prev != 0 && mag > int'(change_limit)) begin
                    v.warning = 1'b1;
                    // saturated counts no longer move the running best
                    if (warn_cnt[dev] != CNT_MAX) begin
                        lead = busiest;
                        warn_cnt[dev] = warn_cnt[dev] + 1'b1;
                        if (warn_cnt[dev] > warn_cnt[lead] ||
                            (warn_cnt[dev] == warn_cnt[lead] && dev < lead)) begin
                            busiest = dev;
                        end
                    end
                end
                last_volt[dev] = volt;
            end
            period      = (report_period == '0) ? RDC_W'(1) : RDC_W'(report_period);
            reading_cnt = reading_cnt + 1'b1;
            if (reading_cnt >= period) begin
                reading_cnt      = '0;
                v.report_valid   = 1'b1;
                v.busiest_device = busiest;
            end
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [7:0] tdata, logic tuser);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $error("result transaction with no reading pending");
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (tdata[0] !== want.warning) begin
                $error("warning mismatch: expected %0d, actual %0d", want.warning, tdata[0]);
                failures++;
            end
            if (tuser !== want.report_valid) begin
                $error("report_valid mismatch: expected %0d, actual %0d",
                       want.report_valid, tuser);
                failures++;
            end
            if (tdata[5:1] !== want.busiest_device) begin
                $error("busiest_device mismatch: expected %0d, actual %0d",
                       want.busiest_device, tdata[5:1]);
                failures++;
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;   // device_id[4:0], voltage[20:5]
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // warning[0], busiest_device[5:1]
    logic             m_tuser;   // report_valid

    verdict_board     verdicts;
    // no idling on either side while set
    bit               steady;
    // last voltage sent per device, only used to shape stimulus
    int               sent_volt [NUM_DEVICES_DEF];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    per_channel_step_change_monitor_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // gap lengths: mostly none or short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // next voltage for a device: mostly steps from its last value at, below or well
    // above the change limit, plus zeros and unrelated full range values
    // ------------------------------------------------------------------------
    function automatic logic [VOLT_W-1:0] next_voltage(logic [DEV_W-1:0] dev);
        int prev;
        int lim;
        int step;
        int pick;
        int v;
        prev = sent_volt[dev];
        lim  = int'(verdicts.change_limit);
        pick = $urandom_range(0, 99);
        if (pick < 8) return '0;
        if (pick < 18 || prev == 0) return VOLT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            step = lim + $urandom_range(0, 2) - 1;
        end else if (pick < 70) begin
            step = $urandom_range(0, lim);
        end else begin
            step = lim + $urandom_range(1, 5000);
        end
        if ($urandom_range(0, 1)) step = -step;
        v = prev + step;
        // reflect a step that leaves the range, then clamp
        if (v > 32767 || v < -32768) v = prev - step;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return VOLT_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // input side: present one reading and hold it until the transaction
    // completes; tvalid stays high into the next reading when there is no gap
    // ------------------------------------------------------------------------
    task automatic send_reading(input logic [DEV_W-1:0] dev, input logic [VOLT_W-1:0] volt);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, volt, dev};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        verdicts.note_reading(dev, volt);
        sent_volt[dev] = int'($signed(volt));
    endtask

    // drop tvalid after the last accepted reading
    task automatic idle_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // hold off until every expected result has come back
    task automatic wait_drained();
        while (verdicts.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        idle_input();
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        verdicts.set_register(idx, val);
    endtask

    // ------------------------------------------------------------------------
    // one random phase under one register setting
    // ------------------------------------------------------------------------
    task automatic run_phase(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] period,
                             input int count);
        logic [DEV_W-1:0] dev;
        write_reg(CFG_CHANGE_LIMIT, limit);
        write_reg(CFG_REPORT_PERIOD, period);
        for (int n = 0; n < count; n++) begin
            // some stretches run with no idling at all
            if (n % 50 == 0) steady = ($urandom_range(0, 4) == 0);
            // sender waits for all results once per phase
            if (n == count / 2) begin
                idle_input();
                wait_drained();
            end
            // a few hot devices so warning counts compete and tie
            if ($urandom_range(0, 9) < 6) begin
                dev = DEV_W'($urandom_range(0, 7));
            end else begin
                dev = DEV_W'($urandom_range(0, NUM_DEVICES_DEF - 1));
            end
            send_reading(dev, next_voltage(dev));
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, then check each accepted transaction
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            verdicts.check_verdict(m_tdata, m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        verdicts = new();
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_CHANGE_LIMIT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        for (int d = 0; d < NUM_DEVICES_DEF; d++) sent_volt[d] = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset limit 30 and period 30
        send_reading(5'd0, 16'sd100);       // no earlier reading
        send_reading(5'd0, 16'sd131);       // step 31, just over the limit
        send_reading(5'd0, 16'sd161);       // step 30, exactly the limit
        send_reading(5'd0, 16'sd0);         // drop to zero still warns
        send_reading(5'd0, 16'sd32767);     // stored zero means no earlier reading
        send_reading(5'd0, -16'sd32768);    // largest possible step
        send_reading(5'd0, -16'sd32738);
        send_reading(5'd31, -16'sd1);
        send_reading(5'd31, 16'sd30);
        send_reading(5'd31, -16'sd1);
        send_reading(5'd31, 16'sd30);       // ties device 0, lower number stays
        for (int k = 1; k <= 5; k++) send_reading(5'd5, 16'(k * 1000));
        for (int k = 0; k < 5; k++) send_reading(5'd3, k[0] ? 16'sd500 : -16'sd500);
        // period lowered below the readings already counted
        write_reg(CFG_REPORT_PERIOD, 16'd5);
        send_reading(5'd1, 16'sd7);
        // limit one below the widest step
        write_reg(CFG_CHANGE_LIMIT, 16'd65534);
        send_reading(5'd2, -16'sd32768);
        send_reading(5'd2, 16'sd32767);
        write_reg(CFG_CHANGE_LIMIT, 16'd65535);
        send_reading(5'd2, -16'sd32768);
        // zero period reports on every reading
        write_reg(CFG_REPORT_PERIOD, 16'd0);
        send_reading(5'd4, 16'sd16);
        send_reading(5'd4, -16'sd16);

        // random phases across settings, extremes among them
        run_phase(16'd0, 16'd1, 140);
        run_phase(16'd65535, 16'd65535, 140);
        run_phase(16'd200, 16'd7, 150);
        run_phase(16'd30, 16'd0, 140);
        run_phase(16'd1000, 16'd13, 140);
        run_phase(16'd65534, 16'd2, 140);
        run_phase(16'($urandom_range(0, 3000)), 16'($urandom_range(1, 40)), 150);
        run_phase(16'd50, 16'd3, 40);

        idle_input();
        wait_drained();
        repeat (8) @(posedge clk);
        if (verdicts.failures == 0 && verdicts.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // run limit, well above the slowest correct run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
